@@ rtl/fire_frame_deposit_and_blur_core_macros.svh @@
// assertion macros used by the fire frame core rtl
`ifndef FIRE_FRAME_DEPOSIT_AND_BLUR_CORE_MACROS_SVH
`define FIRE_FRAME_DEPOSIT_AND_BLUR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define FFDB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define FFDB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ffdb_pkg.sv @@
// shared types and constants of the fire frame deposit and blur block
package ffdb_pkg;

	localparam int PIX_W = 8;
	localparam int SUM_W = 12;

	localparam logic [1:0] OP_DEPOSIT = 2'd0;
	localparam logic [1:0] OP_BLUR    = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam int DEPOSIT_FIRST_ROW = 4;
	localparam logic [PIX_W-1:0] PIXEL_MAX = 8'hFF;

	typedef struct packed {
		logic [1:0] op;
		logic [8:0] col;
		logic [7:0] row;
		logic [7:0] amount;
	} req_item_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       landed;
	} rsp_item_t;

	// stage status passed into and out of the blur datapath
	typedef struct packed {
		logic vld;
		logic calc;
	} stn_ctl_t;

endpackage

@@ rtl/ffdb_frame_mem.sv @@
// frame memory: one write port, two registered read ports
module ffdb_frame_mem #(
	parameter int DEPTH = 64000,
	parameter int AW    = 16
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [ffdb_pkg::PIX_W-1:0] wr_data,
	input  logic                       ra_en,
	input  logic [AW-1:0]              ra_addr,
	output logic [ffdb_pkg::PIX_W-1:0] ra_data,
	input  logic                       rb_en,
	input  logic [AW-1:0]              rb_addr,
	output logic [ffdb_pkg::PIX_W-1:0] rb_data
);

	logic [ffdb_pkg::PIX_W-1:0] mem [DEPTH];
	logic [ffdb_pkg::PIX_W-1:0] ra_q;
	logic [ffdb_pkg::PIX_W-1:0] rb_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read ports
	always_ff @(posedge clk) begin
		if (ra_en) begin
			ra_q <= mem[ra_addr];
		end
		if (rb_en) begin
			rb_q <= mem[rb_addr];
		end
	end

	assign ra_data = ra_q;
	assign rb_data = rb_q;

endmodule

@@ rtl/ffdb_line_buf.sv @@
// circular line buffer: fixed delay of DEPTH steps, read before write
module ffdb_line_buf #(
	parameter int DEPTH = 319
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [ffdb_pkg::PIX_W-1:0] wr_data,
	output logic [ffdb_pkg::PIX_W-1:0] rd_data
);

	localparam int PW = $clog2(DEPTH);

	logic [ffdb_pkg::PIX_W-1:0] mem [DEPTH];
	logic [ffdb_pkg::PIX_W-1:0] rd_q;
	logic [PW-1:0]              ptr_q;

	// old entry comes out while the new one goes in
	always_ff @(posedge clk) begin
		if (en) begin
			rd_q       <= mem[ptr_q];
			mem[ptr_q] <= wr_data;
		end
	end

	// ring pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (en) begin
			ptr_q <= (ptr_q == PW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
		end
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/ffdb_stencil.sv @@
// blur datapath: neighbor window, partial sum, recursive left term
module ffdb_stencil (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ffdb_pkg::stn_ctl_t         ctl_s1,
	input  logic [ffdb_pkg::PIX_W-1:0] below_s1,
	input  logic [ffdb_pkg::PIX_W-1:0] tr_s1,
	input  logic [ffdb_pkg::PIX_W-1:0] right,
	output ffdb_pkg::stn_ctl_t         st_s3,
	output logic [ffdb_pkg::PIX_W-1:0] result
);

	localparam int PW = ffdb_pkg::PIX_W;
	localparam int SW = ffdb_pkg::SUM_W;

	logic          vld_s2, calc_s2, vld_s3, calc_s3;
	logic [PW-1:0] tr_s2, below_s2;
	logic [PW-1:0] top_q, tl_q, c_q, left_q;
	logic [PW-1:0] center_s3;
	logic [SW-1:0] part_s3;
	logic [SW-1:0] partial;
	logic [SW-1:0] total;

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= ctl_s1.vld;
			vld_s3 <= vld_s2;
		end
	end

	// all terms except the left neighbor; c_q holds the unfiltered center
	assign partial = SW'(tl_q) + SW'(top_q) + SW'(tr_s2) + SW'(c_q) + SW'(c_q >> 1)
		+ SW'(c_q >> 2) + SW'(right) + SW'(below_s2);

	// window shift and partial sum register
	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			tr_s2    <= tr_s1;
			below_s2 <= below_s1;
			calc_s2  <= ctl_s1.calc;
		end
		if (vld_s2) begin
			part_s3   <= partial;
			center_s3 <= c_q;
			calc_s3   <= calc_s2;
			c_q       <= right;
			top_q     <= tr_s2;
			tl_q      <= top_q;
		end
	end

	// recursive term: filtered value of the previous pixel, raw if it was not filtered
	assign total  = part_s3 + SW'(left_q);
	assign result = total[PW+2:3];

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			left_q <= calc_s3 ? result : center_s3;
		end
	end

	assign st_s3.vld  = vld_s3;
	assign st_s3.calc = calc_s3;

endmodule

@@ rtl/fire_frame_deposit_and_blur_core.sv @@
// Fire frame core: an 8-bit intensity frame held in one on-chip memory, serving
// deposit, blur and read items, one at a time, each giving one result item.
// After reset a clearing pass writes zero to every pixel, one per cycle,
// and no item is taken until it ends. A deposit or a read runs in two steps:
// address and memory read, then the saturating write or the read data.
// A blur pass streams the frame one pixel per cycle, bounded by the single
// write port of the frame memory, over FRAME_WIDTH*(FRAME_HEIGHT-2)+1 pixel
// positions (one lead-in row). Filtered pixels are written back in place, the
// row above is read back through the second read port, and a line buffer of
// FRAME_WIDTH-1 entries supplies the unfiltered right neighbor.
// A finished result waits in the output register; the next item is accepted
// meanwhile and holds its own result until that register is free.
`include "fire_frame_deposit_and_blur_core_macros.svh"

module fire_frame_deposit_and_blur_core #(
	parameter int FRAME_WIDTH  = 320,
	parameter int FRAME_HEIGHT = 200
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ffdb_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ffdb_pkg::rsp_item_t rsp
);

	localparam int NPIX    = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int AW      = $clog2(NPIX);
	localparam int FIRST_Q = FRAME_WIDTH - 1;
	localparam int CALC_Q  = 2 * FRAME_WIDTH;
	localparam int LAST_Q  = FRAME_WIDTH * (FRAME_HEIGHT - 1) - 1;
	localparam int PW      = ffdb_pkg::PIX_W;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_ACCESS = 5'b00100,
		ST_PASS   = 5'b01000,
		ST_HOLD   = 5'b10000
	} state_t;

	state_t              st_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       q_q;
	logic                issue_q;
	logic                v_s1;
	logic [AW-1:0]       q_s1, q_s2, q_s3;
	logic [1:0]          op_q;
	logic                region_q, frame_q;
	logic [PW-1:0]       amount_q;
	logic [AW-1:0]       addr_q;
	ffdb_pkg::rsp_item_t hold_q;
	logic                rsp_valid_q;
	ffdb_pkg::rsp_item_t rsp_q;

	logic                req_acc, out_free, in_frame, in_region;
	logic [AW-1:0]       addr_in;
	logic                wr_en, ra_en, rb_en;
	logic [AW-1:0]       wr_addr, ra_addr, rb_addr;
	logic [PW-1:0]       wr_data, ra_data, rb_data, lb_data, stn_res;
	logic [PW:0]         dep_sum;
	logic [PW-1:0]       dep_sat;
	logic                pass_done, fin, load_rsp;
	ffdb_pkg::rsp_item_t fin_item;
	ffdb_pkg::stn_ctl_t  ctl_s1, stn_st;

	// input decode
	assign req_stall = (st_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign in_frame  = (int'(req.col) < FRAME_WIDTH) && (int'(req.row) < FRAME_HEIGHT);
	assign in_region = in_frame && (int'(req.row) >= ffdb_pkg::DEPOSIT_FIRST_ROW);
	assign addr_in   = AW'(AW'(req.row) * AW'(FRAME_WIDTH) + AW'(req.col));

	// saturating deposit
	assign dep_sum = {1'b0, ra_data} + {1'b0, amount_q};
	assign dep_sat = dep_sum[PW] ? ffdb_pkg::PIXEL_MAX : dep_sum[PW-1:0];

	// result of the current item
	assign pass_done = stn_st.vld && (q_s3 == AW'(LAST_Q));
	assign fin       = (st_q == ST_ACCESS) || ((st_q == ST_PASS) && pass_done);
	always_comb begin
		fin_item = '0;
		if (st_q == ST_ACCESS) begin
			if (op_q == ffdb_pkg::OP_DEPOSIT && region_q) begin
				fin_item.pixel  = dep_sat;
				fin_item.landed = 1'b1;
			end else if (op_q == ffdb_pkg::OP_READ && frame_q) begin
				fin_item.pixel = ra_data;
			end
		end
	end
	assign load_rsp = out_free && (fin || (st_q == ST_HOLD));

	// memory write port: clearing, deposit, filtered pixel
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		case (st_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_ACCESS: begin
				wr_en   = (op_q == ffdb_pkg::OP_DEPOSIT) && region_q;
				wr_addr = addr_q;
				wr_data = dep_sat;
			end
			ST_PASS: begin
				wr_en   = stn_st.vld && stn_st.calc;
				wr_addr = q_s3;
				wr_data = stn_res;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// read ports: pixel below and updated pixel above-right during a pass
	assign ra_en   = (req_acc && in_frame && req.op != ffdb_pkg::OP_BLUR)
		|| ((st_q == ST_PASS) && issue_q);
	assign ra_addr = (st_q == ST_PASS) ? q_q + AW'(FRAME_WIDTH) : addr_in;
	assign rb_en   = (st_q == ST_PASS) && issue_q;
	assign rb_addr = q_q - AW'(FRAME_WIDTH - 1);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			v_s1 <= (st_q == ST_PASS) && issue_q;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NPIX - 1)) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						if (req.op == ffdb_pkg::OP_BLUR) begin
							st_q    <= ST_PASS;
							issue_q <= 1'b1;
						end else begin
							st_q <= ST_ACCESS;
						end
					end
				end
				ST_ACCESS: begin
					st_q <= out_free ? ST_IDLE : ST_HOLD;
				end
				ST_PASS: begin
					if (issue_q && q_q == AW'(LAST_Q)) begin
						issue_q <= 1'b0;
					end
					if (pass_done) begin
						st_q <= out_free ? ST_IDLE : ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload, pass position and result registers
	always_ff @(posedge clk) begin
		q_s1 <= q_q;
		q_s2 <= q_s1;
		q_s3 <= q_s2;
		if (req_acc) begin
			op_q     <= req.op;
			region_q <= in_region;
			frame_q  <= in_frame;
			amount_q <= req.amount;
			addr_q   <= addr_in;
			q_q      <= AW'(FIRST_Q);
		end else if ((st_q == ST_PASS) && issue_q) begin
			q_q <= q_q + 1'b1;
		end
		if (fin) begin
			hold_q <= fin_item;
		end
		if (load_rsp) begin
			rsp_q <= (st_q == ST_HOLD) ? hold_q : fin_item;
		end
	end

	assign ctl_s1.vld  = v_s1;
	assign ctl_s1.calc = (q_s1 >= AW'(CALC_Q));

	ffdb_frame_mem #(
		.DEPTH(NPIX),
		.AW   (AW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.ra_en  (ra_en),
		.ra_addr(ra_addr),
		.ra_data(ra_data),
		.rb_en  (rb_en),
		.rb_addr(rb_addr),
		.rb_data(rb_data)
	);

	ffdb_line_buf #(
		.DEPTH(FRAME_WIDTH - 1)
	) u_lbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (v_s1),
		.wr_data(ra_data),
		.rd_data(lb_data)
	);

	ffdb_stencil u_stn (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.below_s1(ra_data),
		.tr_s1   (rb_data),
		.right   (lb_data),
		.st_s3   (stn_st),
		.result  (stn_res)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`FFDB_ASSERT_IMPL(a_pass_wr_window, (st_q == ST_PASS) && wr_en,
		(wr_addr >= AW'(CALC_Q)) && (wr_addr <= AW'(LAST_Q)), "blur write outside pass window")
	`FFDB_ASSERT_NEXT(a_issue_once, (st_q == ST_PASS) && !issue_q, !issue_q,
		"pass issue restarted")
	`FFDB_ASSERT_IMPL(a_access_quiet, st_q == ST_ACCESS, !v_s1 && !stn_st.vld,
		"blur pipeline busy during pixel access")
	`FFDB_ASSERT_IMPL(a_clear_no_rsp, st_q == ST_CLEAR, !rsp_valid_q,
		"result during clearing pass")

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the fire frame deposit and blur core
`timescale 1ns / 100ps

module testbench;

	localparam int FRAME_W = 320;
	localparam int FRAME_H = 200;
	localparam int FRAME_PIXELS = FRAME_W * FRAME_H;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// clearing pass plus ten full blur passes, taken several times over
	localparam int CYCLE_LIMIT = 4_000_000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	ffdb_pkg::req_item_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	ffdb_pkg::rsp_item_t rsp;

	// frame as the block should hold it, and results still owed by the block
	logic [7:0] fire_px [FRAME_PIXELS];
	ffdb_pkg::rsp_item_t pending_rsp [$];

	int send_gap_pct;
	int recv_stall_pct;
	int mismatch_count;
	int cycle_count;
	int item_count;
	int blur_count;
	int landed_count;
	int read_count;
	int checked_count;

	fire_frame_deposit_and_blur_core #(
		.FRAME_WIDTH (FRAME_W),
		.FRAME_HEIGHT(FRAME_H)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// one in-place blur pass in raster order, neighbors above and left already new
	function automatic void blur_frame();
		int unsigned c;
		int unsigned sum;
		for (int unsigned p = 2 * FRAME_W; p < FRAME_W * (FRAME_H - 1); p++) begin
			c = fire_px[p];
			sum = fire_px[p - FRAME_W - 1] + fire_px[p - FRAME_W] + fire_px[p - FRAME_W + 1]
				+ fire_px[p - 1] + c + (c >> 1) + (c >> 2)
				+ fire_px[p + 1] + fire_px[p + FRAME_W];
			fire_px[p] = 8'(sum >> 3);
		end
	endfunction

	// apply one item to the frame and give the result it should produce
	function automatic ffdb_pkg::rsp_item_t apply_to_frame(input ffdb_pkg::req_item_t it);
		ffdb_pkg::rsp_item_t r;
		int unsigned ofs;
		int unsigned v;
		r = '0;
		case (it.op)
			ffdb_pkg::OP_DEPOSIT: begin
				if (it.col < FRAME_W && it.row >= ffdb_pkg::DEPOSIT_FIRST_ROW
						&& it.row < FRAME_H) begin
					ofs = it.row * FRAME_W + it.col;
					v = fire_px[ofs] + it.amount;
					if (v > ffdb_pkg::PIXEL_MAX)
						v = ffdb_pkg::PIXEL_MAX;
					fire_px[ofs] = 8'(v);
					r.pixel = 8'(v);
					r.landed = 1'b1;
				end
			end
			ffdb_pkg::OP_BLUR: begin
				blur_frame();
			end
			ffdb_pkg::OP_READ: begin
				if (it.col < FRAME_W && it.row < FRAME_H)
					r.pixel = fire_px[it.row * FRAME_W + it.col];
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic ffdb_pkg::req_item_t fire_req(input logic [1:0] op, input int col,
			input int row, input int amount);
		ffdb_pkg::req_item_t it;
		it.op = op;
		it.col = 9'(col);
		it.row = 8'(row);
		it.amount = 8'(amount);
		return it;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// offer one item, with a random gap first, and predict it once taken
	task automatic offer_item(input ffdb_pkg::req_item_t it);
		if ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(apply_to_frame(it));
		item_count++;
		if (it.op == ffdb_pkg::OP_BLUR)
			blur_count++;
		if (it.op == ffdb_pkg::OP_READ)
			read_count++;
		if (pending_rsp[$].landed)
			landed_count++;
	endtask

	// stop sending until the block has returned everything owed
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// result checking and random receiver stalls
	always @(posedge clk) begin : check_rsp
		ffdb_pkg::rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: pixel %0d landed %0d",
					rsp.pixel, rsp.landed));
			end else begin
				want = pending_rsp.pop_front();
				checked_count++;
				if (rsp.pixel !== want.pixel)
					report_mismatch($sformatf("result %0d pixel got %0d expected %0d",
						checked_count, rsp.pixel, want.pixel));
				if (rsp.landed !== want.landed)
					report_mismatch($sformatf("result %0d landed got %0d expected %0d",
						checked_count, rsp.landed, want.landed));
			end
		end
		rsp_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_rsp.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// region limits, saturation, out-of-frame reads and the unused op code
	task automatic test_region_edges();
		offer_item(fire_req(ffdb_pkg::OP_READ, 0, 0, 0));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 0, 4, 255));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 0, 4, 1));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 319, 199, 200));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 319, 199, 0));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 5, 3, 77));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 0, 0, 255));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 320, 10, 9));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 511, 255, 255));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 10, 200, 5));
		offer_item(fire_req(ffdb_pkg::OP_READ, 319, 199, 0));
		offer_item(fire_req(ffdb_pkg::OP_READ, 320, 0, 0));
		offer_item(fire_req(ffdb_pkg::OP_READ, 511, 255, 255));
		offer_item(fire_req(OP_UNUSED, 511, 255, 255));
	endtask

	// blur around row ends, the top rows and the untouched bottom row
	task automatic test_blur_wrap();
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 319, 5, 255));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 0, 6, 128));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 160, 4, 255));
		offer_item(fire_req(ffdb_pkg::OP_DEPOSIT, 200, 198, 255));
		offer_item(fire_req(ffdb_pkg::OP_BLUR, 0, 0, 0));
		offer_item(fire_req(ffdb_pkg::OP_READ, 0, 6, 0));
		offer_item(fire_req(ffdb_pkg::OP_READ, 319, 5, 0));
		offer_item(fire_req(ffdb_pkg::OP_READ, 1, 6, 0));
		offer_item(fire_req(ffdb_pkg::OP_READ, 160, 3, 0));
		offer_item(fire_req(ffdb_pkg::OP_READ, 160, 2, 0));
		offer_item(fire_req(ffdb_pkg::OP_READ, 200, 199, 0));
	endtask

	// random deposits and reads near hot spots, a few blurs, some noise
	task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int items,
			input int blurs);
		ffdb_pkg::req_item_t it;
		int pick;
		int blurs_left;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		blurs_left = blurs;
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(99);
			case ($urandom_range(2))
				0: it.col = 9'($urandom_range(15));
				1: it.col = 9'($urandom_range(319, 304));
				default: it.col = 9'($urandom_range(319));
			endcase
			case ($urandom_range(3))
				0, 1: it.row = 8'($urandom_range(12, 4));
				2: it.row = 8'($urandom_range(199, 190));
				default: it.row = 8'($urandom_range(199, 4));
			endcase
			it.amount = $urandom_range(1) ? 8'($urandom_range(40)) : 8'($urandom_range(255));
			if (pick < 5 && blurs_left > 0) begin
				it.op = ffdb_pkg::OP_BLUR;
				blurs_left--;
			end else if (pick < 50) begin
				it.op = ffdb_pkg::OP_DEPOSIT;
			end else if (pick < 85) begin
				it.op = ffdb_pkg::OP_READ;
				if ($urandom_range(4) == 0)
					it.row = 8'($urandom_range(3));
			end else begin
				// noise: any field values, mostly outside the frame
				it.op = 2'($urandom_range(3));
				if (it.op == ffdb_pkg::OP_BLUR)
					it.op = OP_UNUSED;
				it.col = 9'($urandom_range(511));
				it.row = 8'($urandom_range(255));
				it.amount = 8'($urandom_range(255));
			end
			offer_item(it);
		end
		// spend any blurs the dice left unused
		while (blurs_left > 0) begin
			offer_item(fire_req(ffdb_pkg::OP_BLUR, 0, 0, 0));
			blurs_left--;
		end
		hold_until_drained();
	endtask

	// test sequence
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		send_gap_pct = 10;
		recv_stall_pct = 61;
		mismatch_count = 0;
		cycle_count = 0;
		item_count = 0;
		blur_count = 0;
		landed_count = 0;
		read_count = 0;
		checked_count = 0;
		foreach (fire_px[i])
			fire_px[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_region_edges();
		test_blur_wrap();
		hold_until_drained();
		test_random_traffic(10, 61, 25, 3);
		test_random_traffic(61, 10, 25, 3);
		test_random_traffic(0, 0, 25, 3);

		repeat (16) @(posedge clk);
		$display("covered %0d items: %0d blur passes, %0d landed deposits, %0d reads",
			item_count, blur_count, landed_count, read_count);
		$display("%0d results checked in %0d cycles, %0d mismatches", checked_count,
			cycle_count, mismatch_count);
		if (mismatch_count == 0 && pending_rsp.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
